// ===== sv/lrb_pkg.sv =====
package lrb_pkg;

  // Field widths of the channels
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  // Default store size
  localparam int DEPTH_DEF = 64;

  // Line terminator
  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

endpackage

// ===== sv/lrb_if.sv =====
interface lrb_in_if
  import lrb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  chunk_length;
  logic              chunk_first;

  modport source (output valid, command, data_byte, chunk_length, chunk_first, input ready);
  modport sink   (input valid, command, data_byte, chunk_length, chunk_first, output ready);
endinterface

interface lrb_out_if
  import lrb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;
  logic              line_valid;
  logic              last_of_run;
  logic              write_accepted;
  logic [LEN_W-1:0]  free_space;
  logic              has_line;

  modport source (output valid, line_byte, line_valid, last_of_run, write_accepted,
                  free_space, has_line, input ready);
  modport sink   (input valid, line_byte, line_valid, last_of_run, write_accepted,
                  free_space, has_line, output ready);
endinterface

// ===== sv/lrb_ram.sv =====
module lrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/line_ring_buffer_core.sv =====
// Channel   Port    Dir  Payload
// -------   ------  ---  -----------------------------------------------------------
// input     in_ch   in   command, data_byte, chunk_length, chunk_first
// result    out_ch  out  line_byte, line_valid, last_of_run, write_accepted,
//                        free_space, has_line
//
// A write byte, or a read while no line is stored, yields one result. A read of a
// line scans the store byte by byte (read, then check) to find the newline, then
// streams the line byte by byte (read, then output, waiting while out_ch stalls);
// its pace is set by the single RAM read port and the shared address adder.
// in_ch.ready is low while a line read runs or the result register is held.
// Reset (rst_n, synchronous) empties the store; no clearing pass is needed.
module line_ring_buffer_core
  import lrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lrb_in_if.sink    in_ch,
  lrb_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_CHK,
    S_EM_RD,
    S_EM_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     nl_r, nl_nxt;
  logic              chunk_acc_r, chunk_acc_nxt;
  logic [AW-1:0]     off_r, off_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_lv_r, out_lv_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_wacc_r, out_wacc_nxt;
  logic [LEN_W-1:0]  out_free_r, out_free_nxt;
  logic              out_has_r, out_has_nxt;

  logic              out_free_slot;
  logic              in_acc;
  logic [CW-1:0]     add_b;
  logic [AW:0]       add_sum;
  logic [AW:0]       add_res;
  logic [AW-1:0]     add_addr;
  logic [LEN_W-1:0]  free_now;
  logic [CW-1:0]     off_plus1;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              chunk_ok;

  assign out_free_slot = !out_valid_r || out_ch.ready;
  assign in_ch.ready   = (state_r == S_IDLE) && out_free_slot;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign free_now      = LEN_W'(DEPTH) - LEN_W'(fill_r);
  assign off_plus1     = CW'(off_r) + CW'(1);

  // Shared circular adder: head plus fill, offset or line length, modulo DEPTH
  always_comb begin
    unique case (state_r)
      S_IDLE:   add_b = fill_r;
      S_EM_OUT: add_b = len_r;
      default:  add_b = CW'(off_r);
    endcase
  end
  assign add_sum  = {1'b0, head_r} + (AW+1)'(add_b);
  assign add_res  = (add_sum >= (AW+1)'(DEPTH)) ? add_sum - (AW+1)'(DEPTH) : add_sum;
  assign add_addr = add_res[AW-1:0];

  // Chunk admission uses the free space before this byte
  assign chunk_ok = in_ch.chunk_first ? (in_ch.chunk_length <= free_now) : chunk_acc_r;

  assign ram_wr_en = in_acc && (in_ch.command == CMD_WRITE) && chunk_ok
                     && (fill_r < CW'(DEPTH));
  assign ram_rd_en = (state_r == S_SC_RD) || (state_r == S_EM_RD);

  lrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(add_addr),
    .wr_data(in_ch.data_byte),
    .rd_en  (ram_rd_en),
    .rd_addr(add_addr),
    .rd_data(ram_rd_data)
  );

  // Sequencer: accept, scan for the newline, then stream the line
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    nl_nxt        = nl_r;
    chunk_acc_nxt = chunk_acc_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_lv_nxt    = out_lv_r;
    out_last_nxt  = out_last_r;
    out_wacc_nxt  = out_wacc_r;
    out_free_nxt  = out_free_r;
    out_has_nxt   = out_has_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_WRITE) begin
            chunk_acc_nxt = chunk_ok;
            if (ram_wr_en) begin
              fill_nxt = fill_r + CW'(1);
              if (in_ch.data_byte == NEWLINE_CODE) begin
                nl_nxt = nl_r + CW'(1);
              end
            end
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_lv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_wacc_nxt  = ram_wr_en;
            out_free_nxt  = LEN_W'(DEPTH) - LEN_W'(fill_nxt);
            out_has_nxt   = (nl_nxt != '0);
          end else if (nl_r == '0) begin
            // Empty read: one blank result, nothing changes
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_lv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_wacc_nxt  = 1'b0;
            out_free_nxt  = free_now;
            out_has_nxt   = 1'b0;
          end else begin
            off_nxt   = '0;
            state_nxt = S_SC_RD;
          end
        end
      end
      S_SC_RD: begin
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (ram_rd_data == NEWLINE_CODE) begin
          // Line length known: commit the final counts before streaming
          len_nxt   = off_plus1;
          fill_nxt  = fill_r - off_plus1;
          nl_nxt    = nl_r - CW'(1);
          off_nxt   = '0;
          state_nxt = S_EM_RD;
        end else begin
          off_nxt   = off_r + AW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_EM_RD: begin
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free_slot) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ram_rd_data;
          out_lv_nxt    = 1'b1;
          out_last_nxt  = (off_plus1 == len_r);
          out_wacc_nxt  = 1'b0;
          out_free_nxt  = free_now;
          out_has_nxt   = (nl_r != '0);
          if (off_plus1 == len_r) begin
            head_nxt  = add_addr;
            state_nxt = S_IDLE;
          end else begin
            off_nxt   = off_r + AW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      nl_r        <= '0;
      chunk_acc_r <= 1'b0;
      off_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      nl_r        <= nl_nxt;
      chunk_acc_r <= chunk_acc_nxt;
      off_r       <= off_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_lv_r   <= out_lv_nxt;
    out_last_r <= out_last_nxt;
    out_wacc_r <= out_wacc_nxt;
    out_free_r <= out_free_nxt;
    out_has_r  <= out_has_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_byte      = out_byte_r;
  assign out_ch.line_valid     = out_lv_r;
  assign out_ch.last_of_run    = out_last_r;
  assign out_ch.write_accepted = out_wacc_r;
  assign out_ch.free_space     = out_free_r;
  assign out_ch.has_line       = out_has_r;

  // Occupancy never exceeds the store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  // Every stored newline sits inside the stored bytes
  a_nl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nl_r <= fill_r)
    else $error("newline count exceeds fill count");

  // A found line is nonempty and fits within what was stored
  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_CHK) && (ram_rd_data == NEWLINE_CODE)
    |=> (len_r != '0) && ($past(fill_r) >= len_r))
    else $error("line length inconsistent with fill count");

  // An accepted write always presents its result next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.command == CMD_WRITE) |=> out_valid_r && out_last_r && !out_lv_r)
    else $error("write result missing");

  // Scanning for and streaming a line happen only with the input side closed
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_OUT) || (state_r == S_SC_CHK) |-> !in_ch.ready)
    else $error("input open during line read");

endmodule

// ===== tb/sv/line_buffer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the results of every input transaction
// and compares each result transaction against the oldest prediction.
module line_buffer_checker
  import lrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lrb_in_if    in_mon,
  lrb_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              line_valid;
    logic              last_of_run;
    logic              write_accepted;
    logic [LEN_W-1:0]  free_space;
    logic              has_line;
  } line_result_t;

  // Shadow copy of the buffer
  logic [BYTE_W-1:0] byte_mem [DEPTH];
  int                rd_head;
  int                fill_cnt;
  int                nl_cnt;
  logic              chunk_open;

  line_result_t owed_results[$];
  int           errors = 0;

  function automatic line_result_t make_result(input logic [BYTE_W-1:0] b,
                                               input logic vld, input logic last,
                                               input logic acc);
    line_result_t r;
    r.line_byte      = b;
    r.line_valid     = vld;
    r.last_of_run    = last;
    r.write_accepted = acc;
    r.free_space     = '0;
    r.has_line       = 1'b0;
    return r;
  endfunction

  // Advance the shadow buffer by one input transaction and queue its results
  task automatic compute_line_results(input logic cmd, input logic [BYTE_W-1:0] data,
                                      input logic [LEN_W-1:0] len, input logic first);
    line_result_t      run_q[$];
    logic [BYTE_W-1:0] b;
    logic              stored;
    stored = 1'b0;
    if (cmd == CMD_WRITE) begin
      // A first byte decides the fate of its whole chunk
      if (first) chunk_open = (int'(len) <= DEPTH - fill_cnt);
      if (chunk_open && fill_cnt < DEPTH) begin
        byte_mem[(rd_head + fill_cnt) % DEPTH] = data;
        fill_cnt++;
        if (data == NEWLINE_CODE) nl_cnt++;
        stored = 1'b1;
      end
      run_q.push_back(make_result('0, 1'b0, 1'b1, stored));
    end else if (nl_cnt == 0) begin
      run_q.push_back(make_result('0, 1'b0, 1'b1, 1'b0));
    end else begin
      // Pop bytes up to and including the next newline
      while (fill_cnt > 0 && run_q.size() < DEPTH) begin
        b       = byte_mem[rd_head];
        rd_head = (rd_head + 1) % DEPTH;
        fill_cnt--;
        run_q.push_back(make_result(b, 1'b1, b == NEWLINE_CODE, 1'b0));
        if (b == NEWLINE_CODE) begin
          nl_cnt--;
          break;
        end
      end
    end
    // Status fields reflect the state after the whole step
    foreach (run_q[k]) begin
      run_q[k].free_space = LEN_W'(DEPTH - fill_cnt);
      run_q[k].has_line   = (nl_cnt != 0);
      owed_results.push_back(run_q[k]);
    end
  endtask

  function automatic void check_field(input string field, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      // Clear the shadow state
      rd_head    = 0;
      fill_cnt   = 0;
      nl_cnt     = 0;
      chunk_open = 1'b0;
      owed_results.delete();
    end else begin
      // Predict on each accepted input transaction
      if (in_mon.valid && in_mon.ready)
        compute_line_results(in_mon.command, in_mon.data_byte, in_mon.chunk_length,
                             in_mon.chunk_first);
      // Compare each accepted result transaction with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no prediction waiting (line_byte 0x%0h)",
                 out_mon.line_byte);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("line_byte", want.line_byte, out_mon.line_byte);
          check_field("line_valid", BYTE_W'(want.line_valid),
                      BYTE_W'(out_mon.line_valid));
          check_field("last_of_run", BYTE_W'(want.last_of_run),
                      BYTE_W'(out_mon.last_of_run));
          check_field("write_accepted", BYTE_W'(want.write_accepted),
                      BYTE_W'(out_mon.write_accepted));
          check_field("free_space", BYTE_W'(want.free_space),
                      BYTE_W'(out_mon.free_space));
          check_field("has_line", BYTE_W'(want.has_line),
                      BYTE_W'(out_mon.has_line));
        end
      end
    end
    fail_count    <= errors;
    pending_count <= owed_results.size();
  end

endmodule

// ===== tb/sv/tb_line_ring_buffer_core.sv =====
`timescale 1ns / 1ps

module tb_line_ring_buffer_core;
  import lrb_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int ITEM_TARGET  = 520;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 10_000_000;

  logic clk = 1'b0;
  logic rst_n;

  lrb_in_if  in_ch ();
  lrb_out_if out_ch ();

  int fail_count;
  int pending_count;
  int items_sent = 0;
  int send_calm = 0;
  int cycle_count;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  line_ring_buffer_core #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  line_buffer_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one item, hold it until the transaction completes, then maybe idle
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] data,
                           input logic [LEN_W-1:0] len, input logic first);
    int gap;
    gap = 0;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.data_byte    <= data;
    in_ch.chunk_length <= len;
    in_ch.chunk_first  <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
    else gap = idle_len(30);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic request_line();
    send_item(CMD_READ, BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)),
              1'($urandom_range(0, 1)));
  endtask

  // Write nbytes; the first one opens a chunk of the announced length if opens is set
  task automatic push_chunk(input int nbytes, input logic [LEN_W-1:0] announced,
                            input int nl_pct, input bit end_nl, input bit opens);
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < nbytes; k++) begin
      if (k == nbytes - 1 && end_nl) b = NEWLINE_CODE;
      else if ($urandom_range(0, 99) < nl_pct) b = NEWLINE_CODE;
      else b = BYTE_W'($urandom_range(0, 255));
      if (k == 0 && opens) send_item(CMD_WRITE, b, announced, 1'b1);
      else send_item(CMD_WRITE, b, LEN_W'($urandom_range(0, 127)), 1'b0);
    end
  endtask

  task automatic run_directed();
    // Read with nothing stored, stray byte after reset
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    send_item(CMD_WRITE, 8'h55, 7'd3, 1'b0);
    // Zero-length chunk is accepted and stays open
    send_item(CMD_WRITE, 8'h00, 7'd0, 1'b1);
    send_item(CMD_WRITE, 8'hFF, 7'd127, 1'b0);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd0, 1'b0);
    send_item(CMD_READ, 8'hFF, 7'd127, 1'b1);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    // Oversized announcements are rejected along with their trailing bytes
    send_item(CMD_WRITE, 8'h41, 7'd127, 1'b1);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd0, 1'b0);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd65, 1'b1);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    // Read while a chunk is still open
    send_item(CMD_WRITE, 8'h61, 7'd64, 1'b1);
    send_item(CMD_WRITE, 8'h62, 7'd5, 1'b0);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd1, 1'b0);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    // Single-byte line, then two lines in one chunk
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd1, 1'b1);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    send_item(CMD_WRITE, 8'h78, 7'd4, 1'b1);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd0, 1'b0);
    send_item(CMD_WRITE, 8'h79, 7'd0, 1'b0);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd0, 1'b0);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
    send_item(CMD_READ, 8'h00, 7'd0, 1'b0);
  endtask

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int gap;
    int calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = 0;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 120);
        else gap = idle_len(25);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Guard against a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[line_ring_buffer_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int n;
    int split;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_WRITE;
    in_ch.data_byte    <= '0;
    in_ch.chunk_length <= '0;
    in_ch.chunk_first  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Random traffic; the receiver starts with a long hold-off
    hold_req <= 1'b1;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // Well-formed chunk ending in a newline
        n = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        push_chunk(n, LEN_W'(n), 12, 1'b1, 1'b1);
      end else if (kind < 75) begin
        request_line();
      end else if (kind < 82) begin
        // Announced length unrelated to the bytes that follow
        n = $urandom_range(1, 12);
        push_chunk(n, LEN_W'($urandom_range(0, 127)), 12, 1'($urandom_range(0, 1)), 1'b1);
      end else if (kind < 88) begin
        send_item(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)));
      end else if (kind < 95) begin
        // Line read in the middle of an open chunk
        n     = $urandom_range(2, 16);
        split = $urandom_range(1, n - 1);
        push_chunk(split, LEN_W'(n), 12, 1'b0, 1'b1);
        request_line();
        push_chunk(n - split, '0, 12, 1'b1, 1'b0);
      end else begin
        // Drain, then a long line; a full store drops the extra bytes
        repeat (16) request_line();
        n = $urandom_range(0, 1) ? DEPTH : $urandom_range(40, DEPTH - 1);
        push_chunk(n, LEN_W'(n), 0, 1'b1, 1'b1);
        if (n == DEPTH) push_chunk(2, '0, 50, 1'b0, 1'b0);
        request_line();
      end
    end
    in_ch.valid <= 1'b0;

    // Wait for every predicted result, then watch for strays
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("[line_ring_buffer_core] OK");
    end else begin
      $display("[line_ring_buffer_core] ERROR");
    end
    $finish;
  end

endmodule
